/* rtl/cdn_pkg.sv */
// Shared types and constants for the civil date/time normalizer.
package cdn_pkg;

  // Day number bias: 1970-01-01 epoch shift plus 100 whole 400-year eras,
  // so that every reachable day number is non-negative.
  localparam int unsigned DnumBias = 15329168;

  typedef struct packed {
    logic [15:0] year;
    logic [12:0] month;
    logic [16:0] day;
    logic [16:0] hour;
    logic [16:0] minute;
    logic [16:0] second;
    logic [32:0] nanos;
  } item_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] nanos;
  } clock_t;

  // After time carry and month wrap
  typedef struct packed {
    logic [16:0] year;   // signed
    logic [3:0]  month;  // 1..12
    logic [17:0] day;    // signed, 1-based
    clock_t      tod;
  } carry_t;

  // Biased day number
  typedef struct packed {
    logic [24:0] dnum;
    clock_t      tod;
  } dnum_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic [2:0]  weekday;
    logic [8:0]  day_in_year;
    logic [5:0]  week;
    logic        ovf;
    clock_t      tod;
  } result_t;

  // Day offset of the 1st of a month within a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/civil_datetime_normalizer.sv */
// Top level: civil date/time normalizer pipeline.
//
// Normalizes a broken-down proleptic Gregorian date and time whose fields may
// be out of range. Nanoseconds, seconds, minutes and hours carry by floor
// division; the month wraps into 1..12 before days are walked across month
// lengths. Also reported: leap-year flag, ISO weekday, day of year, the simple
// week formula (day_in_year - weekday) / 7 + 1, and year_overflow with the year
// saturated to +/-32767 (all other fields still describe the true date).
// Rate: one beat per cycle while the output is not stalled; the result is
// registered through the constant-reciprocal divider stages (five in the
// time carry, two in the day count, eight in the date split). The pipeline
// freezes as a whole while a finished result waits at the output, so
// in_ready is low exactly when out_valid is high and out_ready is low.
module civil_datetime_normalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_year,
  input  logic [12:0] in_month,
  input  logic [16:0] in_day,
  input  logic [16:0] in_hour,
  input  logic [16:0] in_minute,
  input  logic [16:0] in_second,
  input  logic [32:0] in_nanos,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [29:0] out_nanos,
  output logic        leap_year,
  output logic [2:0]  weekday,
  output logic [8:0]  day_in_year,
  output logic [5:0]  week_number,
  output logic        year_overflow
);

  // global advance: output slot free or being taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  cdn_pkg::item_t   item;
  cdn_pkg::carry_t  carry;
  cdn_pkg::dnum_t   dnum;
  cdn_pkg::result_t res;
  logic             v_carry, v_dnum;

  assign item.year   = in_year;
  assign item.month  = in_month;
  assign item.day    = in_day;
  assign item.hour   = in_hour;
  assign item.minute = in_minute;
  assign item.second = in_second;
  assign item.nanos  = in_nanos;

  // nanos/seconds/minutes/hours carry into day, month wrap into year
  cdn_time_carry u_carry (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (in_valid),
    .din  (item),
    .vout (v_carry),
    .dout (carry)
  );

  // date to biased day number
  cdn_day_count u_count (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v_carry),
    .din  (carry),
    .vout (v_dnum),
    .dout (dnum)
  );

  // day number back to date plus calendar extras; last stage is the output reg
  cdn_date_split u_split (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (v_dnum),
    .din  (dnum),
    .vout (out_valid),
    .dout (res)
  );

  assign out_year      = res.year;
  assign out_month     = res.month;
  assign out_day       = res.day;
  assign out_hour      = res.tod.hour;
  assign out_minute    = res.tod.minute;
  assign out_second    = res.tod.second;
  assign out_nanos     = res.tod.nanos;
  assign leap_year     = res.leap;
  assign weekday       = res.weekday;
  assign day_in_year   = res.day_in_year;
  assign week_number   = res.week;
  assign year_overflow = res.ovf;

`ifndef SYNTHESIS
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) &&
                  (out_day >= 5'd1) && (out_day <= 5'd31))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hour < 5'd24) && (out_minute < 6'd60) &&
                  (out_second < 6'd60) && (out_nanos < 30'd1000000000))
    else $error("time field out of range");

  a_week_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (weekday >= 3'd1) && (weekday <= 3'd7) &&
                  (week_number >= 6'd1) && (week_number <= 6'd53) &&
                  (day_in_year >= 9'd1) && (day_in_year <= 9'd365 + 9'(leap_year)))
    else $error("calendar extras out of range");
`endif

endmodule

/* rtl/cdn_time_carry.sv */
// Time-of-day carry chain (ns -> s -> min -> h -> day) and month wrap.
module cdn_time_carry (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  cdn_pkg::item_t  din,
  output logic            vout,
  output cdn_pkg::carry_t dout
);

  localparam logic [33:0] NsSec = 34'd1000000000;
  localparam logic [13:0] K12   = 14'(((64'd1 << 17) + 64'd11) / 64'd12);
  localparam logic [18:0] K60   = 19'(((64'd1 << 24) + 64'd59) / 64'd60);
  localparam logic [18:0] K24   = 19'(((64'd1 << 23) + 64'd23) / 64'd24);

  // stage 1: nanosecond split, month wrap
  logic [33:0] ns_adj;
  logic [3:0]  ns_cnt;
  logic [33:0] ns_rem;
  logic [14:0] mo_s;
  logic [13:0] mo_x;
  logic [27:0] mo_p;
  logic [9:0]  mo_q;
  logic [13:0] mo_r;
  logic [16:0] yr_n;

  always_comb begin
    ns_adj = {din.nanos[32], din.nanos} + 34'd5000000000;
    ns_cnt = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (ns_adj >= 34'(k) * NsSec) ns_cnt = ns_cnt + 4'd1;
    end
    ns_rem = ns_adj - 34'(ns_cnt) * NsSec;
    mo_s = {{2{din.month[12]}}, din.month} + 15'd4103;
    mo_x = mo_s[13:0];
    mo_p = 28'(mo_x) * 28'(K12);
    mo_q = mo_p[26:17];
    mo_r = mo_x - 14'(mo_q) * 14'd12;
    yr_n = {din.year[15], din.year} + {7'd0, mo_q} - 17'd342;
  end

  logic        v1;
  logic [29:0] s1_ns;
  logic [4:0]  s1_nq;
  logic [16:0] s1_yr;
  logic [3:0]  s1_mo;
  logic [16:0] s1_day, s1_hr, s1_mi, s1_se;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vin;
    if (en) begin
      s1_ns  <= ns_rem[29:0];
      s1_nq  <= 5'(ns_cnt) - 5'd5;
      s1_yr  <= yr_n;
      s1_mo  <= mo_r[3:0] + 4'd1;
      s1_day <= din.day;
      s1_hr  <= din.hour;
      s1_mi  <= din.minute;
      s1_se  <= din.second;
    end
  end

  // stage 2: seconds / 60
  logic [18:0] xs_s;
  logic [36:0] xs_p;
  always_comb begin
    xs_s = {{2{s1_se[16]}}, s1_se} + {{14{s1_nq[4]}}, s1_nq} + 19'd66000;
    xs_p = 37'(xs_s[17:0]) * 37'(K60);
  end

  logic        v2;
  logic [17:0] s2_xs;
  logic [11:0] s2_qs;
  logic [29:0] s2_ns;
  logic [16:0] s2_yr;
  logic [3:0]  s2_mo;
  logic [16:0] s2_day, s2_hr, s2_mi;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      s2_xs  <= xs_s[17:0];
      s2_qs  <= xs_p[35:24];
      s2_ns  <= s1_ns;
      s2_yr  <= s1_yr;
      s2_mo  <= s1_mo;
      s2_day <= s1_day;
      s2_hr  <= s1_hr;
      s2_mi  <= s1_mi;
    end
  end

  // stage 3: second remainder, minutes / 60 (carry -1100 and bias +72000 folded)
  logic [17:0] sec_r;
  logic [18:0] xm_s;
  logic [36:0] xm_p;
  always_comb begin
    sec_r = s2_xs - 18'(s2_qs) * 18'd60;
    xm_s  = {{2{s2_mi[16]}}, s2_mi} + 19'(s2_qs) + 19'd70900;
    xm_p  = 37'(xm_s[17:0]) * 37'(K60);
  end

  logic        v3;
  logic [17:0] s3_xm;
  logic [11:0] s3_qm;
  logic [5:0]  s3_se;
  logic [29:0] s3_ns;
  logic [16:0] s3_yr;
  logic [3:0]  s3_mo;
  logic [16:0] s3_day, s3_hr;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      s3_xm  <= xm_s[17:0];
      s3_qm  <= xm_p[35:24];
      s3_se  <= sec_r[5:0];
      s3_ns  <= s2_ns;
      s3_yr  <= s2_yr;
      s3_mo  <= s2_mo;
      s3_day <= s2_day;
      s3_hr  <= s2_hr;
    end
  end

  // stage 4: minute remainder, hours / 24 (carry -1200 and bias +67200 folded)
  logic [17:0] min_r;
  logic [18:0] xh_s;
  logic [36:0] xh_p;
  always_comb begin
    min_r = s3_xm - 18'(s3_qm) * 18'd60;
    xh_s  = {{2{s3_hr[16]}}, s3_hr} + 19'(s3_qm) + 19'd66000;
    xh_p  = 37'(xh_s[17:0]) * 37'(K24);
  end

  logic        v4;
  logic [17:0] s4_xh;
  logic [12:0] s4_qh;
  logic [5:0]  s4_mi, s4_se;
  logic [29:0] s4_ns;
  logic [16:0] s4_yr;
  logic [3:0]  s4_mo;
  logic [16:0] s4_day;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      s4_xh  <= xh_s[17:0];
      s4_qh  <= xh_p[35:23];
      s4_mi  <= min_r[5:0];
      s4_se  <= s3_se;
      s4_ns  <= s3_ns;
      s4_yr  <= s3_yr;
      s4_mo  <= s3_mo;
      s4_day <= s3_day;
    end
  end

  // stage 5: hour remainder, day carry
  logic [17:0] hr_r;
  logic [17:0] dy_n;
  always_comb begin
    hr_r = s4_xh - 18'(s4_qh) * 18'd24;
    dy_n = {s4_day[16], s4_day} + 18'(s4_qh) - 18'd2800;
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= v4;
    if (en) begin
      dout.year       <= s4_yr;
      dout.month      <= s4_mo;
      dout.day        <= dy_n;
      dout.tod.hour   <= hr_r[4:0];
      dout.tod.minute <= s4_mi;
      dout.tod.second <= s4_se;
      dout.tod.nanos  <= s4_ns;
    end
  end

endmodule

/* rtl/cdn_day_count.sv */
// Civil date (year, month, day offset) to biased day number, two stages.
module cdn_day_count (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  cdn_pkg::carry_t din,
  output logic            vout,
  output cdn_pkg::dnum_t  dout
);

  localparam logic [17:0] K100 = 18'(((64'd1 << 24) + 64'd99) / 64'd100);

  // stage 1: March-based year, biased by 40000 (100 eras), and its quotients
  logic        jan;
  logic [17:0] ys;
  logic [16:0] yb;
  logic [34:0] p100;
  logic [32:0] p400;

  always_comb begin
    jan  = (din.month <= 4'd2);
    ys   = {din.year[16], din.year} - 18'(jan) + 18'd40000;
    yb   = ys[16:0];
    p100 = 35'(yb) * 35'(K100);
    p400 = 33'(yb[16:2]) * 33'(K100);
  end

  logic           v1;
  logic [16:0]    s1_y;
  logic [9:0]     s1_q100;
  logic [7:0]     s1_q400;
  logic [8:0]     s1_ms;
  logic [17:0]    s1_day;
  cdn_pkg::clock_t s1_tod;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vin;
    if (en) begin
      s1_y    <= yb;
      s1_q100 <= p100[33:24];
      s1_q400 <= p400[31:24];
      s1_ms   <= cdn_pkg::month_start(din.month);
      s1_day  <= din.day;
      s1_tod  <= din.tod;
    end
  end

  // stage 2: day number sum
  logic [27:0] zs;
  always_comb begin
    zs = 28'(s1_y) * 28'd365 + 28'(s1_y[16:2]) - 28'(s1_q100) + 28'(s1_q400)
       + 28'(s1_ms) + {{10{s1_day[17]}}, s1_day} - 28'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= v1;
    if (en) begin
      dout.dnum <= zs[24:0];
      dout.tod  <= s1_tod;
    end
  end

endmodule

/* rtl/cdn_date_split.sv */
// Biased day number back to year/month/day, weekday, ordinal day and week.
module cdn_date_split (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vin,
  input  cdn_pkg::dnum_t   din,
  output logic             vout,
  output cdn_pkg::result_t dout
);

  localparam int          NStg   = 8;
  localparam logic [26:0] KEra   = 27'(((64'd1 << 44) + 64'd146096) / 64'd146097);
  localparam logic [26:0] K7z    = 27'(((64'd1 << 29) + 64'd6) / 64'd7);
  localparam logic [18:0] K1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] K36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] K365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  K100y  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] K153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] K5     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam logic [9:0]  K7w    = 10'(((64'd1 << 12) + 64'd6) / 64'd7);
  // Offset so that (dnum + C7) mod 7 + 1 is the ISO weekday
  localparam logic [25:0] C7 =
    26'(((3 - int'(cdn_pkg::DnumBias)) % 7 + 7) % 7);

  // time of day rides alongside stages 1..7, the last stage loads it into dout
  logic            v [NStg];
  cdn_pkg::clock_t tod [NStg-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NStg; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= vin;
      for (int i = 1; i < NStg; i++) v[i] <= v[i-1];
    end
    if (en) begin
      tod[0] <= din.tod;
      for (int i = 1; i < NStg-1; i++) tod[i] <= tod[i-1];
    end
  end

  // stage 1: era
  logic [51:0] pe;
  assign pe = 52'(din.dnum) * 52'(KEra);

  logic [24:0] s1_z;
  logic [7:0]  s1_era;
  always_ff @(posedge clk) begin
    if (en) begin
      s1_z   <= din.dnum;
      s1_era <= pe[51:44];
    end
  end

  // stage 2: day of era, weekday quotient
  logic [24:0] doe_w;
  logic [25:0] wn;
  logic [52:0] pw;
  always_comb begin
    doe_w = s1_z - 25'(s1_era) * 25'd146097;
    wn    = 26'(s1_z) + C7;
    pw    = 53'(wn) * 53'(K7z);
  end

  logic [17:0] s2_doe;
  logic [7:0]  s2_era;
  logic [25:0] s2_w;
  logic [23:0] s2_wq;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_doe <= doe_w[17:0];
      s2_era <= s1_era;
      s2_w   <= wn;
      s2_wq  <= pw[52:29];
    end
  end

  // stage 3: weekday, leap-day corrections for year of era
  logic [25:0] wr;
  logic [36:0] pa, pb;
  logic [17:0] tt;
  always_comb begin
    wr = s2_w - 26'(s2_wq) * 26'd7;
    pa = 37'(s2_doe) * 37'(K1460);
    pb = 37'(s2_doe) * 37'(K36524);
    tt = s2_doe - 18'(pa[36:29]) + 18'(pb[36:34]) - 18'(s2_doe == 18'd146096);
  end

  logic [17:0] s3_t, s3_doe;
  logic [7:0]  s3_era;
  logic [2:0]  s3_wd;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_t   <= tt;
      s3_doe <= s2_doe;
      s3_era <= s2_era;
      s3_wd  <= wr[2:0] + 3'd1;
    end
  end

  // stage 4: year of era
  logic [36:0] py;
  assign py = 37'(s3_t) * 37'(K365);

  logic [8:0]  s4_yoe;
  logic [17:0] s4_doe;
  logic [7:0]  s4_era;
  logic [2:0]  s4_wd;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_yoe <= py[35:27];
      s4_doe <= s3_doe;
      s4_era <= s3_era;
      s4_wd  <= s3_wd;
    end
  end

  // stage 5: March-based day of year
  logic [18:0] pq;
  logic [17:0] doy_w;
  always_comb begin
    pq    = 19'(s4_yoe) * 19'(K100y);
    doy_w = s4_doe - (18'(s4_yoe) * 18'd365 + 18'(s4_yoe[8:2]) - 18'(pq[18:16]));
  end

  logic [8:0] s5_doy, s5_yoe;
  logic [7:0] s5_era;
  logic [2:0] s5_wd;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_doy <= doy_w[8:0];
      s5_yoe <= s4_yoe;
      s5_era <= s4_era;
      s5_wd  <= s4_wd;
    end
  end

  // stage 6: March-based month
  logic [10:0] x5;
  logic [22:0] pm;
  always_comb begin
    x5 = 11'(s5_doy) * 11'd5 + 11'd2;
    pm = 23'(x5) * 23'(K153);
  end

  logic [3:0] s6_mp;
  logic [8:0] s6_doy, s6_yoe;
  logic [7:0] s6_era;
  logic [2:0] s6_wd;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_mp  <= pm[22:19];
      s6_doy <= s5_doy;
      s6_yoe <= s5_yoe;
      s6_era <= s5_era;
      s6_wd  <= s5_wd;
    end
  end

  // stage 7: day, month, year, leap, ordinal day, saturation
  logic [10:0]        x153;
  logic [22:0]        pd;
  logic [8:0]         dd;
  logic               jan;
  logic [8:0]         r;
  logic signed [17:0] yt;
  logic               lp, ovf;
  logic [8:0]         diy;

  always_comb begin
    x153 = 11'(s6_mp) * 11'd153 + 11'd2;
    pd   = 23'(x153) * 23'(K5);
    dd   = s6_doy - pd[22:14] + 9'd1;
    jan  = (s6_mp >= 4'd10);
    r    = s6_yoe + 9'(jan);
    yt   = $signed(18'(s6_era) * 18'd400 + 18'(r) - 18'd40000);
    // divisible by 4, and not a century unless a multiple of 400
    lp   = (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    ovf  = (yt > 18'sd32767) || (yt < -18'sd32767);
    diy  = jan ? (s6_doy - 9'd305) : (s6_doy + 9'd60 + 9'(lp));
  end

  logic [15:0] s7_year;
  logic [3:0]  s7_month;
  logic [4:0]  s7_day;
  logic        s7_leap, s7_ovf;
  logic [8:0]  s7_diy;
  logic [2:0]  s7_wd;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!ovf) s7_year <= yt[15:0];
      else if (yt[17]) s7_year <= 16'h8001;
      else s7_year <= 16'h7FFF;
      s7_month <= jan ? (s6_mp - 4'd9) : (s6_mp + 4'd3);
      s7_day   <= dd[4:0];
      s7_leap  <= lp;
      s7_ovf   <= ovf;
      s7_diy   <= diy;
      s7_wd    <= s6_wd;
    end
  end

  // stage 8: week number, truncated toward zero
  logic [9:0]  dw;
  logic [18:0] pk;
  logic [5:0]  wk;
  always_comb begin
    dw = {1'b0, s7_diy} - 10'(s7_wd);
    pk = 19'(dw[8:0]) * 19'(K7w);
    wk = (dw[9] ? 6'd0 : pk[17:12]) + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.year        <= s7_year;
      dout.month       <= s7_month;
      dout.day         <= s7_day;
      dout.leap        <= s7_leap;
      dout.weekday     <= s7_wd;
      dout.day_in_year <= s7_diy;
      dout.week        <= wk;
      dout.ovf         <= s7_ovf;
      dout.tod         <= tod[NStg-2];
    end
  end

  assign vout = v[NStg-1];

endmodule
